/* rtl/srctok_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srctok_pkg;

  // Byte offset counter width; lexeme fields are always 16 bits wide.
  localparam int OFFSET_WIDTH = 16;
  localparam int LEX_W        = 16;
  localparam int KIND_W       = 6;
  localparam int PREFIX_DEPTH = 6;
  localparam int PREFIX_IDX_W = 3;
  localparam int NUM_KW       = 10;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [LEX_W-1:0] LEN_MAX = {LEX_W{1'b1}};

  // Token kinds
  localparam logic [KIND_W-1:0] K_COMMA         = 6'd0;
  localparam logic [KIND_W-1:0] K_PERIOD        = 6'd1;
  localparam logic [KIND_W-1:0] K_COLON         = 6'd2;
  localparam logic [KIND_W-1:0] K_SEMICOLON     = 6'd3;
  localparam logic [KIND_W-1:0] K_L_PAREN       = 6'd4;
  localparam logic [KIND_W-1:0] K_R_PAREN       = 6'd5;
  localparam logic [KIND_W-1:0] K_L_BRACKET     = 6'd6;
  localparam logic [KIND_W-1:0] K_R_BRACKET     = 6'd7;
  localparam logic [KIND_W-1:0] K_L_CURLY       = 6'd8;
  localparam logic [KIND_W-1:0] K_R_CURLY       = 6'd9;
  localparam logic [KIND_W-1:0] K_NOT_EQUAL     = 6'd10;
  localparam logic [KIND_W-1:0] K_BANG          = 6'd11;
  localparam logic [KIND_W-1:0] K_QUESTION_MARK = 6'd12;
  localparam logic [KIND_W-1:0] K_EQUAL         = 6'd13;
  localparam logic [KIND_W-1:0] K_ASSIGN        = 6'd14;
  localparam logic [KIND_W-1:0] K_MINUS         = 6'd15;
  localparam logic [KIND_W-1:0] K_PLUS          = 6'd16;
  localparam logic [KIND_W-1:0] K_ASTERISK      = 6'd17;
  localparam logic [KIND_W-1:0] K_GT            = 6'd18;
  localparam logic [KIND_W-1:0] K_LT            = 6'd19;
  localparam logic [KIND_W-1:0] K_STRING        = 6'd20;
  localparam logic [KIND_W-1:0] K_EOF           = 6'd21;
  localparam logic [KIND_W-1:0] K_INT           = 6'd22;
  localparam logic [KIND_W-1:0] K_ILLEGAL       = 6'd23;
  localparam logic [KIND_W-1:0] K_FIRST_KEYWORD = 6'd24;
  localparam logic [KIND_W-1:0] K_IDENT         = 6'd34;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_STR  = 3'd3,
    MODE_BANG = 3'd4,
    MODE_EQ   = 3'd5
  } scan_mode_t;

  typedef struct packed {
    logic              is_zero;
    logic              is_space;
    logic              is_letter;
    logic              is_digit;
    logic              is_bang;
    logic              is_eq;
    logic              is_quote;
    logic              punct_hit;
    logic [KIND_W-1:0] punct_kind;
  } byte_class_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEX_W-1:0]  start;
    logic [LEX_W-1:0]  length;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

  // Keyword text, byte j of entry i at kw_text(i)[j]; unused bytes are zero.
  function automatic prefix_t kw_text(input int unsigned idx);
    prefix_t t;
    t = '0;
    case (idx)
      0: t[2:0] = {8'h74, 8'h65, 8'h6C};                             // let
      1: t[5:0] = {8'h6E, 8'h72, 8'h75, 8'h74, 8'h65, 8'h72};         // return
      2: t[1:0] = {8'h6E, 8'h66};                                    // fn
      3: t[4:0] = {8'h74, 8'h73, 8'h6E, 8'h6F, 8'h63};               // const
      4: t[2:0] = {8'h65, 8'h73, 8'h75};                             // use
      5: t[3:0] = {8'h65, 8'h75, 8'h72, 8'h74};                      // true
      6: t[4:0] = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};               // false
      7: t[2:0] = {8'h74, 8'h6E, 8'h69};                             // int
      8: t[5:0] = {8'h67, 8'h6E, 8'h69, 8'h72, 8'h74, 8'h73};         // string
      9: t[3:0] = {8'h6C, 8'h6F, 8'h6F, 8'h62};                      // bool
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned idx);
    logic [2:0] l;
    case (idx)
      0: l = 3'd3;
      1: l = 3'd6;
      2: l = 3'd2;
      3: l = 3'd5;
      4: l = 3'd3;
      5: l = 3'd4;
      6: l = 3'd5;
      7: l = 3'd3;
      8: l = 3'd6;
      9: l = 3'd4;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  // Exact keyword match over the stored word prefix; anything else is IDENT.
  function automatic logic [KIND_W-1:0] word_kind(input prefix_t pfx,
                                                  input logic [LEX_W-1:0] len);
    logic [KIND_W-1:0] k;
    logic              hit;
    prefix_t           t;
    logic [2:0]        l;
    k = K_IDENT;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      t   = kw_text(i);
      l   = kw_len(i);
      hit = (len == LEX_W'(l));
      for (int j = 0; j < PREFIX_DEPTH; j++) begin
        if (j < int'(l) && pfx[j] != t[j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        k = K_FIRST_KEYWORD + KIND_W'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [LEX_W-1:0] sat_inc(input logic [LEX_W-1:0] v);
    return (v == LEN_MAX) ? v : v + LEX_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/srctok_class.sv */
`timescale 1ns / 1ps
`default_nettype none

module srctok_class (
  input  wire logic [7:0]              ch,
  output srctok_pkg::byte_class_t      cls
);

  always_comb begin
    cls            = '0;
    cls.is_zero    = (ch == srctok_pkg::CH_NUL);
    cls.is_space   = (ch == srctok_pkg::CH_SPACE) || (ch == srctok_pkg::CH_TAB) ||
                     (ch == srctok_pkg::CH_CR) || (ch == srctok_pkg::CH_LF);
    cls.is_letter  = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
                     (ch == 8'h5F);
    cls.is_digit   = (ch >= 8'h30 && ch <= 8'h39);
    cls.is_bang    = (ch == srctok_pkg::CH_BANG);
    cls.is_eq      = (ch == srctok_pkg::CH_EQ);
    cls.is_quote   = (ch == srctok_pkg::CH_QUOTE);
    cls.punct_hit  = 1'b1;
    case (ch)
      8'h2C:   cls.punct_kind = srctok_pkg::K_COMMA;
      8'h2E:   cls.punct_kind = srctok_pkg::K_PERIOD;
      8'h3A:   cls.punct_kind = srctok_pkg::K_COLON;
      8'h3B:   cls.punct_kind = srctok_pkg::K_SEMICOLON;
      8'h28:   cls.punct_kind = srctok_pkg::K_L_PAREN;
      8'h29:   cls.punct_kind = srctok_pkg::K_R_PAREN;
      8'h5B:   cls.punct_kind = srctok_pkg::K_L_BRACKET;
      8'h5D:   cls.punct_kind = srctok_pkg::K_R_BRACKET;
      8'h7B:   cls.punct_kind = srctok_pkg::K_L_CURLY;
      8'h7D:   cls.punct_kind = srctok_pkg::K_R_CURLY;
      8'h3F:   cls.punct_kind = srctok_pkg::K_QUESTION_MARK;
      8'h2D:   cls.punct_kind = srctok_pkg::K_MINUS;
      8'h2B:   cls.punct_kind = srctok_pkg::K_PLUS;
      8'h2A:   cls.punct_kind = srctok_pkg::K_ASTERISK;
      8'h3E:   cls.punct_kind = srctok_pkg::K_GT;
      8'h3C:   cls.punct_kind = srctok_pkg::K_LT;
      default: begin
        cls.punct_hit  = 1'b0;
        cls.punct_kind = srctok_pkg::K_ILLEGAL;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/srctok_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module srctok_scan (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    acc,
  input  wire logic [7:0]              ch,
  input  wire srctok_pkg::byte_class_t cls,
  output srctok_pkg::push_t            push
);

  localparam int OW = srctok_pkg::OFFSET_WIDTH;
  localparam int LW = srctok_pkg::LEX_W;

  srctok_pkg::scan_mode_t mode_r, mode_nxt;
  logic [OW-1:0]          off_r, off_nxt;
  logic [OW-1:0]          start_r, start_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  srctok_pkg::prefix_t    pfx_r;

  logic                                 redo;
  logic                                 pfx_we;
  logic [srctok_pkg::PREFIX_IDX_W-1:0]  pfx_idx;
  logic                                 pend_v, idle_v;
  srctok_pkg::token_t                   pend_t, idle_t;

  // Pending token closed by this byte, after which the byte starts fresh.
  always_comb begin
    case (mode_r)
      srctok_pkg::MODE_WORD: redo = !cls.is_letter;
      srctok_pkg::MODE_NUM:  redo = !cls.is_digit;
      srctok_pkg::MODE_STR:  redo = cls.is_zero;
      srctok_pkg::MODE_BANG,
      srctok_pkg::MODE_EQ:   redo = !cls.is_eq;
      default:               redo = 1'b1;
    endcase
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    if (acc) begin
      if (redo) begin
        if (cls.is_zero || cls.is_space || cls.punct_hit) begin
          mode_nxt = srctok_pkg::MODE_IDLE;
        end else if (cls.is_bang) begin
          mode_nxt = srctok_pkg::MODE_BANG;
        end else if (cls.is_eq) begin
          mode_nxt = srctok_pkg::MODE_EQ;
        end else if (cls.is_quote) begin
          mode_nxt = srctok_pkg::MODE_STR;
        end else if (cls.is_letter) begin
          mode_nxt = srctok_pkg::MODE_WORD;
        end else if (cls.is_digit) begin
          mode_nxt = srctok_pkg::MODE_NUM;
        end else begin
          mode_nxt = srctok_pkg::MODE_IDLE;
        end
      end else begin
        case (mode_r)
          srctok_pkg::MODE_STR:  mode_nxt = cls.is_quote ? srctok_pkg::MODE_IDLE : mode_r;
          srctok_pkg::MODE_BANG,
          srctok_pkg::MODE_EQ:   mode_nxt = srctok_pkg::MODE_IDLE;
          default:               mode_nxt = mode_r;
        endcase
      end
    end
  end

  // Results and datapath updates
  always_comb begin
    off_nxt   = off_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pfx_we    = 1'b0;
    pfx_idx   = '0;
    pend_v    = 1'b0;
    pend_t    = '0;
    idle_v    = 1'b0;
    idle_t    = '0;

    pend_t.start  = LW'(start_r);
    pend_t.length = len_r;

    case (mode_r)
      srctok_pkg::MODE_WORD: begin
        if (cls.is_letter) begin
          if (len_r < LW'(srctok_pkg::PREFIX_DEPTH)) begin
            pfx_we  = 1'b1;
            pfx_idx = len_r[srctok_pkg::PREFIX_IDX_W-1:0];
          end
          len_nxt = srctok_pkg::sat_inc(len_r);
        end else begin
          pend_v      = 1'b1;
          pend_t.kind = srctok_pkg::word_kind(pfx_r, len_r);
        end
      end
      srctok_pkg::MODE_NUM: begin
        if (cls.is_digit) begin
          len_nxt = srctok_pkg::sat_inc(len_r);
        end else begin
          pend_v      = 1'b1;
          pend_t.kind = srctok_pkg::K_INT;
        end
      end
      srctok_pkg::MODE_STR: begin
        if (cls.is_quote || cls.is_zero) begin
          pend_v      = 1'b1;
          pend_t.kind = srctok_pkg::K_STRING;
        end else begin
          len_nxt = srctok_pkg::sat_inc(len_r);
        end
      end
      srctok_pkg::MODE_BANG,
      srctok_pkg::MODE_EQ: begin
        pend_v = 1'b1;
        if (cls.is_eq) begin
          pend_t.kind   = (mode_r == srctok_pkg::MODE_BANG) ? srctok_pkg::K_NOT_EQUAL
                                                           : srctok_pkg::K_EQUAL;
          pend_t.length = LW'(2);
        end else begin
          pend_t.kind   = (mode_r == srctok_pkg::MODE_BANG) ? srctok_pkg::K_BANG
                                                           : srctok_pkg::K_ASSIGN;
          pend_t.length = LW'(1);
        end
      end
      default: ;
    endcase

    // Handle the byte as if no token were open
    if (redo) begin
      idle_t.start  = LW'(off_r);
      idle_t.length = LW'(1);
      if (cls.is_space) begin
        idle_v = 1'b0;
      end else if (cls.is_zero) begin
        idle_v        = 1'b1;
        idle_t.kind   = srctok_pkg::K_EOF;
        idle_t.length = '0;
      end else if (cls.punct_hit) begin
        idle_v      = 1'b1;
        idle_t.kind = cls.punct_kind;
      end else begin
        start_nxt = off_r;
        len_nxt   = LW'(1);
        if (cls.is_quote) begin
          start_nxt = off_r + OW'(1);
          len_nxt   = '0;
        end else if (cls.is_letter) begin
          pfx_we  = 1'b1;
          pfx_idx = '0;
        end else if (!cls.is_bang && !cls.is_eq && !cls.is_digit) begin
          len_nxt     = '0;
          idle_v      = 1'b1;
          idle_t.kind = srctok_pkg::K_ILLEGAL;
        end
      end
    end

    // End marker returns everything to the reset state
    if (cls.is_zero) begin
      off_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
    end else begin
      off_nxt = off_r + OW'(1);
    end

    pend_t.last = !idle_v;
    idle_t.last = 1'b1;

    push.cnt  = {1'b0, pend_v} + {1'b0, idle_v};
    push.tok0 = pend_v ? pend_t : idle_t;
    push.tok1 = idle_t;
    if (!acc) begin
      push.cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= srctok_pkg::MODE_IDLE;
      off_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      if (acc) begin
        off_r   <= off_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // Word prefix holds no reset: only entries written by the current word are compared.
  always_ff @(posedge clk) begin
    if (acc && pfx_we) begin
      pfx_r[pfx_idx] <= ch;
    end
  end

endmodule

`default_nettype wire

/* rtl/srctok_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module srctok_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srctok_pkg::push_t  push,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srctok_pkg::token_t      out_tok
);

  localparam int PW = srctok_pkg::Q_PTR_W;
  localparam int CW = srctok_pkg::Q_CNT_W;

  srctok_pkg::token_t mem_r [srctok_pkg::Q_DEPTH];
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_tok   = mem_r[rp_r];
  // Keep room for the two beats a single byte can produce.
  assign room      = (cnt_r <= CW'(srctok_pkg::Q_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PW'(push.cnt);
    rp_nxt  = rp_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + PW'(1)] <= push.tok1;
    end
  end

endmodule

`default_nettype wire

/* rtl/source_tokenizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat                                          Handshake
// in_       input      in_byte (8b source character, 0 = end)         in_valid / in_ready
// out_      output     out_token_kind, out_lexeme_start,              out_valid / out_ready
//                      out_lexeme_length, out_last_of_run
//
// One byte is taken per cycle; the scanner state updates in the cycle the byte is
// accepted and its tokens (zero, one or two) land in a four-entry result queue.
// A byte that closes a pending token and also forms one itself yields two beats,
// so sustained input rate is one byte per cycle as long as the consumer keeps up.
// in_ready drops while the queue holds more than two beats; out_ready low only
// fills the queue. Synchronous active-low reset clears the scanner and the queue.
// The end marker emits EOF and returns the scanner to its reset state.

module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_token_kind,
  output logic [15:0]      out_lexeme_start,
  output logic [15:0]      out_lexeme_length,
  output logic             out_last_of_run
);

  srctok_pkg::byte_class_t cls;
  srctok_pkg::push_t       push;
  srctok_pkg::token_t      tok;
  logic                    room;
  logic                    acc;

  // Accept a byte only while the queue can hold both beats it may cause.
  assign in_ready = room;
  assign acc      = in_valid && room;

  srctok_class u_class (
    .ch  (in_byte),
    .cls (cls)
  );

  srctok_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_byte),
    .cls   (cls),
    .push  (push)
  );

  srctok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (tok)
  );

  assign out_token_kind    = tok.kind;
  assign out_lexeme_start  = tok.start;
  assign out_lexeme_length = tok.length;
  assign out_last_of_run   = tok.last;

endmodule

`default_nettype wire

/* dv/tb_source_tokenizer.sv */
`timescale 1ns / 1ps

// Self-checking bench for source_tokenizer. Each source byte accepted on the in_
// channel runs through a local lexer that keeps its own scan state; the tokens
// it yields queue up and every out_ beat is checked against the oldest one.

module tb_source_tokenizer;
  import srctok_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int HOLD_OFF     = 300;     // long consumer stall right after reset
  localparam int QUIET_LIMIT  = 4000;    // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_STRING  = 40;      // string body sent with no idling
  localparam int RANDOM_BYTES = 530;

  // One token as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEX_W-1:0]  start;
    logic [LEX_W-1:0]  len;
    logic              last;
  } lexeme_t;

  // How the tokens of a scripted byte are checked
  typedef enum logic [1:0] {
    ROW_PREDICT,   // whatever the local lexer says
    ROW_SILENT,    // no token at all
    ROW_ONE        // exactly the token typed into the row
  } row_check_t;

  typedef struct packed {
    row_check_t how;
    lexeme_t    tok;
  } row_pin_t;

  typedef struct packed {
    logic [7:0] ch;
    row_pin_t   pin;
  } script_row_t;

  localparam row_pin_t UNPINNED = '{how: ROW_PREDICT, tok: '0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [5:0]        out_token_kind;
  logic [15:0]       out_lexeme_start;
  logic [15:0]       out_lexeme_length;
  logic              out_last_of_run;

  // Travels with in_byte so the scoreboard knows how to check the beat it sees
  row_pin_t          offer_pin = UNPINNED;

  // Local lexer state
  scan_mode_t              scan_state = MODE_IDLE;
  logic [OFFSET_WIDTH-1:0] scan_offset = '0;
  logic [OFFSET_WIDTH-1:0] scan_start = '0;
  logic [LEX_W-1:0]        scan_len = '0;
  logic [7:0]              word_head [PREFIX_DEPTH];

  lexeme_t    fresh[$];              // tokens of the byte just lexed
  lexeme_t    expected_lexemes[$];   // tokens still owed by the block
  logic [7:0] source_text[$];

  string keyword_spelling [NUM_KW] = '{"let", "return", "fn", "const", "use",
                                       "true", "false", "int", "string", "bool"};
  string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digit_chars = "0123456789";
  string punct_chars = ",.:;()[]{}?-+*><";
  logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  bit steady = 1'b0;                 // no idling on either side while set
  int sender_calm = 0;
  int receiver_calm = 0;
  int quiet_cycles = 0;
  int bytes_lexed = 0;
  int tokens_checked = 0;
  int keywords_seen = 0;
  int failures = 0;

  source_tokenizer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_lexeme_start  (out_lexeme_start),
    .out_lexeme_length (out_lexeme_length),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local lexer
  // ---------------------------------------------------------------------------

  function automatic bit is_word_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int punct_code(input logic [7:0] c);
    case (c)
      ",":     return K_COMMA;
      ".":     return K_PERIOD;
      ":":     return K_COLON;
      ";":     return K_SEMICOLON;
      "(":     return K_L_PAREN;
      ")":     return K_R_PAREN;
      "[":     return K_L_BRACKET;
      "]":     return K_R_BRACKET;
      "{":     return K_L_CURLY;
      "}":     return K_R_CURLY;
      "?":     return K_QUESTION_MARK;
      "-":     return K_MINUS;
      "+":     return K_PLUS;
      "*":     return K_ASTERISK;
      ">":     return K_GT;
      "<":     return K_LT;
      default: return -1;
    endcase
  endfunction

  function automatic void tally(input logic [KIND_W-1:0] k,
                                input logic [OFFSET_WIDTH-1:0] s,
                                input logic [LEX_W-1:0] l);
    fresh.push_back('{kind: k, start: LEX_W'(s), len: l, last: 1'b0});
  endfunction

  // Exact match only: a word longer than the stored head is never a keyword
  function automatic logic [KIND_W-1:0] word_code();
    string kw;
    bit    same;
    if (scan_len > PREFIX_DEPTH) return K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      kw = keyword_spelling[i];
      if (kw.len() == scan_len) begin
        same = 1'b1;
        for (int j = 0; j < kw.len(); j++) begin
          if (word_head[j] != kw[j]) same = 1'b0;
        end
        if (same) return K_FIRST_KEYWORD + KIND_W'(i);
      end
    end
    return K_IDENT;
  endfunction

  // Advance the scan by one byte; tokens land in fresh
  function automatic void lex_byte(input logic [7:0] c);
    bit reopen;
    bit grow;
    int p;
    reopen = 1'b0;
    grow   = 1'b0;
    case (scan_state)
      MODE_WORD: begin
        if (is_word_byte(c)) begin
          if (scan_len < PREFIX_DEPTH) word_head[scan_len[PREFIX_IDX_W-1:0]] = c;
          grow = 1'b1;
        end else begin
          tally(word_code(), scan_start, scan_len);
          reopen = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_num(c)) begin
          grow = 1'b1;
        end else begin
          tally(K_INT, scan_start, scan_len);
          reopen = 1'b1;
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          tally(K_STRING, scan_start, scan_len);
          scan_state = MODE_IDLE;
        end else if (c == CH_NUL) begin
          // unterminated string: close it, then the end marker gives EOF
          tally(K_STRING, scan_start, scan_len);
          reopen = 1'b1;
        end else begin
          grow = 1'b1;
        end
      end
      MODE_BANG, MODE_EQ: begin
        if (c == CH_EQ) begin
          tally(scan_state == MODE_BANG ? K_NOT_EQUAL : K_EQUAL, scan_start, 2);
          scan_state = MODE_IDLE;
        end else begin
          tally(scan_state == MODE_BANG ? K_BANG : K_ASSIGN, scan_start, 1);
          reopen = 1'b1;
        end
      end
      default: reopen = 1'b1;
    endcase

    if (grow) scan_len = (scan_len == LEN_MAX) ? scan_len : scan_len + 1'b1;

    // Handle the byte as if no token were open
    if (reopen) begin
      scan_state = MODE_IDLE;
      p = punct_code(c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      end else if (c == CH_NUL) begin
        tally(K_EOF, scan_offset, 0);
      end else if (p >= 0) begin
        tally(KIND_W'(p), scan_offset, 1);
      end else if (c == CH_QUOTE) begin
        scan_state = MODE_STR;
        scan_start = scan_offset + 1'b1;
        scan_len   = '0;
      end else if (c == CH_BANG || c == CH_EQ || is_word_byte(c) || is_num(c)) begin
        scan_start = scan_offset;
        scan_len   = 1;
        if (c == CH_BANG) scan_state = MODE_BANG;
        else if (c == CH_EQ) scan_state = MODE_EQ;
        else if (is_num(c)) scan_state = MODE_NUM;
        else begin
          scan_state   = MODE_WORD;
          word_head[0] = c;
        end
      end else begin
        scan_start = scan_offset;
        scan_len   = '0;
        tally(K_ILLEGAL, scan_offset, 1);
      end
    end

    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;

    // End marker returns everything to its reset state
    if (c == CH_NUL && scan_state == MODE_IDLE) begin
      scan_offset = '0;
      scan_start  = '0;
      scan_len    = '0;
    end else begin
      scan_offset = scan_offset + 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: lex accepted bytes, check accepted tokens, watch for a hang
  // ---------------------------------------------------------------------------

  function automatic bit field_diff(input string what, input logic [15:0] want,
                                    input logic [15:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    lexeme_t want;
    bit      bad;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        bytes_lexed++;
        fresh.delete();
        lex_byte(in_byte);
        case (offer_pin.how)
          ROW_ONE:    expected_lexemes.push_back(offer_pin.tok);
          ROW_SILENT: ;
          default:    foreach (fresh[i]) expected_lexemes.push_back(fresh[i]);
        endcase
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (expected_lexemes.size() == 0) begin
          $display("%0t: unexpected token, kind %0d start %0d length %0d", $time,
                   out_token_kind, out_lexeme_start, out_lexeme_length);
          failures++;
        end else begin
          want = expected_lexemes.pop_front();
          bad = field_diff("token_kind", 16'(want.kind), 16'(out_token_kind))
              | field_diff("lexeme_start", want.start, out_lexeme_start)
              | field_diff("lexeme_length", want.len, out_lexeme_length)
              | field_diff("last_of_run", 16'(want.last), 16'(out_last_of_run));
          if (bad) failures++;
          tokens_checked++;
          if (want.kind >= K_FIRST_KEYWORD && want.kind < K_IDENT) keywords_seen++;
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d tokens still owed", $time,
                 QUIET_LIMIT, expected_lexemes.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------

  // Mostly short pauses, now and then a long one, and calm stretches with none
  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Consumer: hold off long right after reset so the block fills and stalls
  // its input, then take beats with random pauses
  initial begin : consumer
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    forever begin
      g = steady ? 0 : pause_len(receiver_calm);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the block takes the beat
  task automatic offer(input logic [7:0] b, input row_pin_t pin);
    int g;
    g = steady ? 0 : pause_len(sender_calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    offer_pin <= pin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic feed_text();
    foreach (source_text[i]) offer(source_text[i], UNPINNED);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
  endfunction

  // Mostly well-formed tokens with random content; some noise and broken ones
  function automatic void compose_source(input int target);
    int         pick;
    int         n;
    string      w;
    logic [7:0] c;
    while (source_text.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // keyword, sometimes bent into a near miss
        w = keyword_spelling[$urandom_range(0, NUM_KW - 1)];
        case ($urandom_range(0, 5))
          0:       w = {w, "s"};
          1:       w = w.substr(0, w.len() - 2);
          2:       w[0] = w[0] - 8'h20;
          default: ;
        endcase
        push_text(w);
      end else if (pick < 40) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        repeat (n) source_text.push_back(word_chars[$urandom_range(0, 52)]);
      end else if (pick < 52) begin
        repeat ($urandom_range(1, 6)) source_text.push_back(digit_chars[$urandom_range(0, 9)]);
      end else if (pick < 62) begin
        source_text.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
          source_text.push_back(c);
        end
        // now and then leave the string open into the end marker
        source_text.push_back($urandom_range(0, 9) == 0 ? CH_NUL : CH_QUOTE);
      end else if (pick < 85) begin
        n = $urandom_range(0, 19);
        if (n < 16) source_text.push_back(punct_chars[n]);
        else if (n == 16) push_text("!");
        else if (n == 17) push_text("=");
        else if (n == 18) push_text("!=");
        else push_text("==");
      end else if (pick < 95) begin
        source_text.push_back(8'($urandom_range(0, 255)));
      end else begin
        source_text.push_back(CH_NUL);
      end
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) source_text.push_back(blank_chars[$urandom_range(0, 3)]);
      end
    end
    // flush whatever is still open
    source_text.push_back(CH_NUL);
  endfunction

  function automatic script_row_t pinned_line(input logic [7:0] c,
                                              input logic [KIND_W-1:0] k,
                                              input logic [LEX_W-1:0] s,
                                              input logic [LEX_W-1:0] l);
    return '{ch: c, pin: '{how: ROW_ONE, tok: '{kind: k, start: s, len: l, last: 1'b1}}};
  endfunction

  function automatic script_row_t quiet_line(input logic [7:0] c);
    return '{ch: c, pin: '{how: ROW_SILENT, tok: '0}};
  endfunction

  function automatic script_row_t predicted_line(input logic [7:0] c);
    return '{ch: c, pin: UNPINNED};
  endfunction

  initial begin : stimulus
    script_row_t opening[$];
    logic [7:0]  c;

    // Offsets in the comments count from reset and restart after each end marker
    opening = '{
      pinned_line(8'hFF, K_ILLEGAL, 0, 1),      // top byte value right after reset
      pinned_line("}", K_R_CURLY, 1, 1),
      quiet_line("!"),
      pinned_line("=", K_NOT_EQUAL, 2, 2),
      quiet_line("="),
      pinned_line("=", K_EQUAL, 4, 2),
      quiet_line("!"),
      predicted_line("f"),                       // lone bang closed by a letter
      predicted_line("n"),
      predicted_line("("),                       // keyword and paren from one byte
      predicted_line("4"),
      predicted_line("2"),
      predicted_line(CH_QUOTE),                  // number closed by a quote
      predicted_line(8'h01),                     // control and high bytes as content
      predicted_line(8'hFF),
      predicted_line(CH_QUOTE),
      pinned_line(8'h01, K_ILLEGAL, 16, 1),      // control byte outside a string
      quiet_line(CH_TAB),
      quiet_line("="),
      predicted_line(CH_NUL),                    // pending assign, then EOF
      pinned_line(CH_NUL, K_EOF, 0, 0),          // end marker on a fresh scan
      quiet_line(CH_QUOTE),
      predicted_line("z"),
      predicted_line(CH_NUL),                    // unterminated string, then EOF
      quiet_line("!"),
      predicted_line(CH_NUL)                     // pending bang, then EOF
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) offer(opening[i].ch, opening[i].pin);

    // One long string streamed back to back with no idling on either side
    steady = 1'b1;
    source_text.push_back(CH_QUOTE);
    repeat (LONG_STRING) begin
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
      source_text.push_back(c);
    end
    source_text.push_back(CH_QUOTE);
    push_text("x 12 ");
    source_text.push_back(CH_NUL);
    feed_text();
    steady = 1'b0;

    source_text.delete();
    compose_source(RANDOM_BYTES);
    feed_text();
    in_valid <= 1'b0;

    while (expected_lexemes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d bytes (scripted opening, one %0d-byte string, random text)",
             bytes_lexed, LONG_STRING);
    $display("Compared %0d tokens, %0d of them keywords; %0d failures",
             tokens_checked, keywords_seen, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/srctok_pkg.sv
rtl/srctok_class.sv
rtl/srctok_scan.sv
rtl/srctok_queue.sv
rtl/source_tokenizer.sv
dv/tb_source_tokenizer.sv
